>>> design/fwrp_pkg.sv
`default_nettype none
package fwrp_pkg;

  // store depth, a power of two so that slot addresses wrap on their own
  localparam int DEPTH  = 16;
  localparam int ELEM_W = 32;
  localparam int POS_W  = 4;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int IN_DATA_W  = ((ELEM_W + POS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ELEM_W + 1 + CNT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_PEEK    = 2'd3
  } op_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [ELEM_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic              ok;
    logic [ELEM_W-1:0] element;
    logic              is_empty;
    logic [CNT_W-1:0]  count;
  } result_t;

endpackage
`default_nettype wire

>>> design/fwrp_store.sv
`default_nettype none
module fwrp_store (
  input  wire logic                      clk,
  input  wire fwrp_pkg::mem_req_t        req,
  output logic [fwrp_pkg::ELEM_W-1:0]    rdata
);
  import fwrp_pkg::*;

  logic [ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

>>> design/fwrp_ctrl.sv
`default_nettype none
module fwrp_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire fwrp_pkg::op_t              in_op,
  input  wire logic [fwrp_pkg::ELEM_W-1:0] in_elem,
  input  wire logic [fwrp_pkg::POS_W-1:0] in_pos,
  output fwrp_pkg::mem_req_t              mem_req,
  input  wire logic [fwrp_pkg::ELEM_W-1:0] mem_rdata,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output fwrp_pkg::result_t               res
);
  import fwrp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_RDATA = 6'b000100,
    S_CMP   = 6'b001000,
    S_SHIFT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state, state_next;
  op_t               op, op_next;
  logic [ELEM_W-1:0] elem, elem_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [IDX_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  k, k_next;
  logic              res_ok, res_ok_next;
  logic [ELEM_W-1:0] res_elem, res_elem_next;

  logic [CNT_W-1:0]  k1, k2;
  logic [IDX_W-1:0]  addr_k, addr_k1, addr_k2;

  assign k1      = k + CNT_W'(1);
  assign k2      = k + CNT_W'(2);
  assign addr_k  = head + k[IDX_W-1:0];
  assign addr_k1 = head + k1[IDX_W-1:0];
  assign addr_k2 = head + k2[IDX_W-1:0];

  always_comb begin
    state_next    = state;
    op_next       = op;
    elem_next     = elem;
    pos_next      = pos;
    head_next     = head;
    count_next    = count;
    k_next        = k;
    res_ok_next   = res_ok;
    res_elem_next = res_elem;
    mem_req.we    = 1'b0;
    mem_req.waddr = addr_k;
    mem_req.wdata = elem;
    mem_req.raddr = head;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next       = in_op;
          elem_next     = in_elem;
          pos_next      = in_pos;
          res_ok_next   = 1'b0;
          res_elem_next = '0;
          k_next        = '0;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        unique case (op)
          OP_ENQUEUE: begin
            if (count < CNT_W'(DEPTH)) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = head + count[IDX_W-1:0];
              count_next    = count + CNT_W'(1);
              res_ok_next   = 1'b1;
            end
          end
          OP_DEQUEUE: begin
            mem_req.raddr = head;
            if (count != '0) begin
              state_next = S_RDATA;
            end
          end
          OP_REMOVE: begin
            mem_req.raddr = head;
            if (count != '0) begin
              state_next = S_CMP;
            end
          end
          OP_PEEK: begin
            mem_req.raddr = head + IDX_W'(pos);
            if (CNT_W'(pos) < count) begin
              state_next = S_RDATA;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_RDATA: begin
        res_ok_next   = 1'b1;
        res_elem_next = mem_rdata;
        if (op == OP_DEQUEUE) begin
          head_next  = head + IDX_W'(1);
          count_next = count - CNT_W'(1);
        end
        state_next = S_DONE;
      end
      S_CMP: begin
        mem_req.raddr = addr_k1;
        if (mem_rdata == elem) begin
          if (k1 < count) begin
            state_next = S_SHIFT;
          end else begin
            count_next  = count - CNT_W'(1);
            res_ok_next = 1'b1;
            state_next  = S_DONE;
          end
        end else if (k1 < count) begin
          k_next = k1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        // pull the entry behind up into the freed slot
        mem_req.we    = 1'b1;
        mem_req.waddr = addr_k;
        mem_req.wdata = mem_rdata;
        mem_req.raddr = addr_k2;
        k_next        = k1;
        if (k2 >= count) begin
          count_next  = count - CNT_W'(1);
          res_ok_next = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
    op       <= op_next;
    elem     <= elem_next;
    pos      <= pos_next;
    k        <= k_next;
    res_ok   <= res_ok_next;
    res_elem <= res_elem_next;
  end

  assign in_ready     = (state == S_IDLE);
  assign res_valid    = (state == S_DONE);
  assign res.ok       = res_ok;
  assign res.element  = res_elem;
  assign res.is_empty = (count == '0);
  assign res.count    = count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + CNT_W'(1)) ||
    (count + CNT_W'(1) == $past(count)))
    else $error("entry count moved by more than one");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == S_EXEC) || (state == S_SHIFT))
    else $error("store written outside enqueue or shift");

  a_count_only_in_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) || (state == S_DONE) |=> count == $past(count))
    else $error("entry count changed while idle or holding a result");

endmodule
`default_nettype wire

>>> design/fifo_with_remove_and_peek_core.sv
// channel  | dir | beat fields (tdata/tuser)
// s_axis   | in  | tuser: operation; tdata: element, position
// m_axis   | out | tuser: ok; tdata: element_out, is_empty, entry_count
//
// enqueue, a failed dequeue or peek, and remove on an empty queue pass S_EXEC then S_DONE;
// a dequeue or peek that hits adds S_RDATA. remove reads the store once per compared slot,
// then reads and writes once per slot moved up, all through a single port pair
// one item at a time; a result waits in the output register while the next runs
// with the output stalled the next result holds in the core and s_axis_tready stays low
// rst is synchronous and empties the queue
`default_nettype none
module fifo_with_remove_and_peek_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [fwrp_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // element, position, zero pad
  input  wire logic [1:0]                        s_axis_tuser,  // operation
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [fwrp_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // element_out, is_empty, entry_count
  output logic [0:0]                             m_axis_tuser   // ok
);
  import fwrp_pkg::*;

  mem_req_t          mem_req;
  logic [ELEM_W-1:0] mem_rdata;
  logic              res_valid, res_ready;
  result_t           res;
  result_t           out_res;
  op_t               in_op;

  assign in_op = op_t'(s_axis_tuser);

  fwrp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (in_op),
    .in_elem   (s_axis_tdata[ELEM_W-1:0]),
    .in_pos    (s_axis_tdata[ELEM_W +: POS_W]),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  fwrp_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tuser = out_res.ok;
  assign m_axis_tdata = {(OUT_DATA_W - ELEM_W - 1 - CNT_W)'(0),
                         out_res.count, out_res.is_empty, out_res.element};

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !out_res.ok |-> out_res.element == '0)
    else $error("failed result carries a nonzero element");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_res.is_empty == (out_res.count == '0))
    else $error("empty flag disagrees with count");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while busy");

endmodule
`default_nettype wire

>>> bench/fifo_with_remove_and_peek_core_test.sv
`timescale 1ns / 1ps
module fifo_with_remove_and_peek_core_test;
  import fwrp_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int REPORT_LIMIT = 10;
  localparam int SETTLE_CYCLES = 3 * DEPTH + 16;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = OP_ENQUEUE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  result_t           results_due[$];
  logic [ELEM_W-1:0] shadow_entries[$];
  logic [ELEM_W-1:0] value_pool[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5,
                                       32'h5A5A_5A5A, 32'h0000_0001, 32'h8000_0000,
                                       32'h1234_5678, 32'hDEAD_BEEF};
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                error_count = 0;
  int                cycle_count = 0;

  fifo_with_remove_and_peek_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // element, position, zero pad
    .s_axis_tuser  (s_axis_tuser),   // operation
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // element_out, is_empty, entry_count, zero pad
    .m_axis_tuser  (m_axis_tuser)    // ok
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t apply_queue_op(op_t op, logic [ELEM_W-1:0] element,
                                             logic [POS_W-1:0] position);
    result_t r;
    int      hit;
    r   = '0;
    hit = -1;
    case (op)
      OP_ENQUEUE: begin
        if (shadow_entries.size() < DEPTH) begin
          shadow_entries.push_back(element);
          r.ok = 1'b1;
        end
      end
      OP_DEQUEUE: begin
        if (shadow_entries.size() > 0) begin
          r.element = shadow_entries.pop_front();
          r.ok      = 1'b1;
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < shadow_entries.size(); i++)
          if (hit < 0 && shadow_entries[i] == element) hit = i;
        if (hit >= 0) begin
          shadow_entries.delete(hit);
          r.ok = 1'b1;
        end
      end
      default: begin
        if (int'(position) < shadow_entries.size()) begin
          r.element = shadow_entries[position];
          r.ok      = 1'b1;
        end
      end
    endcase
    r.is_empty = (shadow_entries.size() == 0);
    r.count    = CNT_W'(shadow_entries.size());
    return r;
  endfunction

  // called at a rising edge, returns at the edge where the beat was taken
  task automatic send_request(op_t op, logic [ELEM_W-1:0] element, logic [POS_W-1:0] position);
    logic [IN_DATA_W-1:0] beat;
    beat = '0;
    beat[ELEM_W-1:0]      = element;
    beat[ELEM_W +: POS_W] = position;
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= beat;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    results_due.push_back(apply_queue_op(op, element, position));
  endtask

  function automatic logic [ELEM_W-1:0] pick_element();
    if ($urandom_range(0, 3) == 0) return ELEM_W'($urandom());
    return value_pool[$urandom_range(0, 7)];
  endfunction

  task automatic test_empty_queue();
    send_request(OP_DEQUEUE, '0, '0);
    send_request(OP_REMOVE, '0, '0);
    send_request(OP_PEEK, '0, 4'd0);
    send_request(OP_PEEK, '0, 4'd15);
  endtask

  task automatic test_field_extremes();
    send_request(OP_ENQUEUE, 32'h0000_0000, 4'd15);
    send_request(OP_ENQUEUE, 32'hFFFF_FFFF, 4'd0);
    send_request(OP_PEEK, '0, 4'd0);
    send_request(OP_PEEK, '0, 4'd1);
    send_request(OP_PEEK, 32'hFFFF_FFFF, 4'd2);
    send_request(OP_REMOVE, 32'hFFFF_FFFF, 4'd0);
    send_request(OP_DEQUEUE, '0, '0);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < DEPTH; i++)
      send_request(OP_ENQUEUE, value_pool[i % 3], POS_W'(i));
    send_request(OP_ENQUEUE, 32'h7777_7777, '0);
    send_request(OP_PEEK, '0, 4'd15);
    // duplicates: only the first from the front goes
    send_request(OP_REMOVE, value_pool[1], '0);
    send_request(OP_REMOVE, 32'h7777_7777, '0);
    send_request(OP_PEEK, '0, 4'd15);
  endtask

  // alternate filling and draining stretches so both full and empty recur
  task automatic test_random_traffic(int items, int idle, int stall);
    int   roll;
    op_t  op;
    logic [ELEM_W-1:0] element;
    idle_pct  = idle;
    stall_pct = stall;
    for (int k = 0; k < items; k++) begin
      roll = $urandom_range(0, 99);
      if ((k / 40) % 2 == 0)
        op = roll < 55 ? OP_ENQUEUE : roll < 70 ? OP_DEQUEUE : roll < 85 ? OP_REMOVE : OP_PEEK;
      else
        op = roll < 20 ? OP_ENQUEUE : roll < 55 ? OP_DEQUEUE : roll < 80 ? OP_REMOVE : OP_PEEK;
      element = pick_element();
      if (op == OP_REMOVE && shadow_entries.size() > 0 && $urandom_range(0, 9) < 7)
        element = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
      send_request(op, element, POS_W'($urandom_range(0, 15)));
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got          = '0;
      got.ok       = m_axis_tuser[0];
      got.element  = m_axis_tdata[ELEM_W-1:0];
      got.is_empty = m_axis_tdata[ELEM_W];
      got.count    = m_axis_tdata[ELEM_W+1 +: CNT_W];
      if (results_due.size() == 0) begin
        if (error_count < REPORT_LIMIT)
          $display("unexpected result beat: ok=%0b element=%h empty=%0b count=%0d",
                   got.ok, got.element, got.is_empty, got.count);
        error_count++;
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          if (error_count < REPORT_LIMIT)
            $display({"mismatch: expected ok=%0b element=%h empty=%0b count=%0d, ",
                      "got ok=%0b element=%h empty=%0b count=%0d"},
                     want.ok, want.element, want.is_empty, want.count,
                     got.ok, got.element, got.is_empty, got.count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queue();
    test_field_extremes();
    test_full_queue();
    test_random_traffic(150, 0, 0);
    test_random_traffic(150, 70, 0);
    test_random_traffic(150, 0, 70);
    test_random_traffic(150, 33, 33);
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (results_due.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
